[hw/rtl/rrss_pkg.sv]
// Shared types and constants of the round-robin slice scheduler.
`default_nettype none

package rrss_pkg;

  localparam int unsigned FuncW    = 2;
  localparam int unsigned BurstW   = 16;
  localparam int unsigned QuantumW = 16;
  localparam int unsigned TimeW    = 24;
  localparam int unsigned JobNumW  = 5;

  localparam logic [TimeW-1:0]    TimeMax        = {TimeW{1'b1}};
  localparam logic [QuantumW-1:0] QuantumResetVal = QuantumW'(4);

  // Item function codes
  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_ADVANCE = 2'd1,
    FUNC_CLEAR   = 2'd2
  } rrss_func_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GRANT,
    ST_RESULT
  } rrss_state_e;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [BurstW-1:0] burst_time;
  } rrss_in_t;

  typedef struct packed {
    logic [JobNumW-1:0] job_number;
    logic [TimeW-1:0]   slice_end_time;
    logic               job_finished;
    logic [TimeW-1:0]   turnaround_time;
    logic [TimeW-1:0]   waiting_time;
    logic               all_done;
  } rrss_out_t;

endpackage

`default_nettype wire

[hw/rtl/rrss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rrss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/round_robin_slice_scheduler_core.sv]
// Round-robin time-slice scheduler: job tables in RAM, sequencer and result register.
// Load, clear and unused-code transactions give no result and do not stall the input.
// An advance scans the table from the scan position for the next entry with work left,
// grants it a slice in ST_GRANT and registers the result in ST_RESULT (all_done if none
// has work or the table is empty). Input stalls until then, longer while a result is stalled.
// Reset clears job count, scan position, clock and output valid, sets the quantum to 4.
`default_nettype none

module round_robin_slice_scheduler_core
  import rrss_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [QuantumW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire rrss_in_t            in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      rrss_out_t           out_data_o
);

  localparam int unsigned IdxW = $clog2(MAX_JOBS);
  localparam int unsigned CntW = $clog2(MAX_JOBS + 1);

  rrss_state_e state_q, state_d;

  logic [QuantumW-1:0] quantum_q;
  logic [CntW-1:0]     job_cnt_q;
  logic [IdxW-1:0]     scan_pos_q;
  logic [TimeW-1:0]    time_q;

  logic [IdxW-1:0]     addr_q;
  logic [CntW-1:0]     issued_q;
  logic                chk_valid_q;
  logic [IdxW-1:0]     chk_addr_q;
  logic                chk_last_q;

  logic                found_q;
  logic                fin_q;
  logic [IdxW-1:0]     idx_q;
  logic [BurstW-1:0]   rem_q;
  logic [BurstW-1:0]   burst_q;

  logic                out_valid_q;
  rrss_out_t           out_data_q;

  logic                in_acc;
  logic                is_load;
  logic                is_adv;
  logic                is_clear;
  logic                load_ok;
  logic                scan_issue;
  logic                found_hit;
  logic                out_load;
  logic                out_take;

  logic [BurstW-1:0]   rem_rdata;
  logic [BurstW-1:0]   burst_rdata;
  logic                rem_we;
  logic [IdxW-1:0]     rem_waddr;
  logic [BurstW-1:0]   rem_wdata;

  logic [IdxW-1:0]     start_pos;
  logic [IdxW-1:0]     addr_next;
  logic [IdxW-1:0]     scan_pos_next;
  logic [QuantumW-1:0] quantum_eff;
  logic [BurstW-1:0]   grant;
  logic [BurstW-1:0]   rem_new;
  logic [TimeW:0]      time_sum;
  logic [TimeW-1:0]    time_new;
  logic [TimeW-1:0]    wait_time;
  rrss_out_t           out_next;

  // Decode the incoming transaction
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_load    = in_acc && (in_data_i.func == FUNC_LOAD);
  assign is_adv     = in_acc && (in_data_i.func == FUNC_ADVANCE);
  assign is_clear   = in_acc && (in_data_i.func == FUNC_CLEAR);
  assign load_ok    = is_load && (job_cnt_q < CntW'(MAX_JOBS));
  assign out_take   = out_valid_q && !out_stall_i;

  // Wrap table positions at the job count
  assign start_pos     = (CntW'(scan_pos_q) >= job_cnt_q) ? '0 : scan_pos_q;
  assign addr_next     = ((CntW'(addr_q) + CntW'(1)) == job_cnt_q) ? '0
                                                                    : IdxW'(addr_q + 1'b1);
  assign scan_pos_next = ((CntW'(idx_q) + CntW'(1)) == job_cnt_q) ? '0
                                                                   : IdxW'(idx_q + 1'b1);

  // Grant arithmetic on the found entry
  assign quantum_eff = (quantum_q == '0) ? QuantumW'(1) : quantum_q;
  assign grant       = (rem_q > quantum_eff) ? quantum_eff : rem_q;
  assign rem_new     = rem_q - grant;
  assign time_sum    = {1'b0, time_q} + (TimeW + 1)'(grant);
  assign time_new    = time_sum[TimeW] ? TimeMax : time_sum[TimeW-1:0];

  // Next state and sequencer controls
  always_comb begin
    state_d    = state_q;
    scan_issue = 1'b0;
    found_hit  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (is_adv) begin
          state_d = (job_cnt_q == '0) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_issue = (issued_q < job_cnt_q);
        if (chk_valid_q) begin
          if (rem_rdata != '0) begin
            found_hit = 1'b1;
            state_d   = ST_GRANT;
          end else if (chk_last_q) begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_GRANT: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the quantum, job count, scan position and clock
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q  <= QuantumResetVal;
      job_cnt_q  <= '0;
      scan_pos_q <= '0;
      time_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        quantum_q <= cfg_wdata_i;
      end
      if (is_clear) begin
        job_cnt_q  <= '0;
        scan_pos_q <= '0;
        time_q     <= '0;
      end else if (load_ok) begin
        job_cnt_q <= job_cnt_q + CntW'(1);
      end else if (state_q == ST_GRANT) begin
        time_q     <= time_new;
        scan_pos_q <= scan_pos_next;
      end
    end
  end

  // Scan pointer and read-check pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      chk_valid_q <= scan_issue;
      if (is_adv) begin
        found_q <= 1'b0;
      end else if (found_hit) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_adv) begin
      addr_q   <= start_pos;
      issued_q <= '0;
    end else if (scan_issue) begin
      addr_q   <= addr_next;
      issued_q <= issued_q + CntW'(1);
    end
    if (scan_issue) begin
      chk_addr_q <= addr_q;
      chk_last_q <= (issued_q == (job_cnt_q - CntW'(1)));
    end
    if (found_hit) begin
      idx_q   <= chk_addr_q;
      rem_q   <= rem_rdata;
      burst_q <= burst_rdata;
    end
    if (state_q == ST_GRANT) begin
      fin_q <= (rem_new == '0);
    end
  end

  // Remaining-work write: load fills a new entry, grant writes back the found one
  assign rem_we    = load_ok || (state_q == ST_GRANT);
  assign rem_waddr = load_ok ? job_cnt_q[IdxW-1:0] : idx_q;
  assign rem_wdata = load_ok ? in_data_i.burst_time : rem_new;

  rrss_ram #(
    .WIDTH (BurstW),
    .DEPTH (MAX_JOBS)
  ) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .re_i    (scan_issue),
    .raddr_i (addr_q),
    .rdata_o (rem_rdata)
  );

  rrss_ram #(
    .WIDTH (BurstW),
    .DEPTH (MAX_JOBS)
  ) u_burst_ram (
    .clk_i   (clk_i),
    .we_i    (load_ok),
    .waddr_i (job_cnt_q[IdxW-1:0]),
    .wdata_i (in_data_i.burst_time),
    .re_i    (scan_issue),
    .raddr_i (addr_q),
    .rdata_o (burst_rdata)
  );

  // Build the result transaction
  assign wait_time = (time_q >= TimeW'(burst_q)) ? (time_q - TimeW'(burst_q)) : '0;

  always_comb begin
    out_next                = '0;
    out_next.slice_end_time = time_q;
    if (found_q) begin
      out_next.job_number = JobNumW'(CntW'(idx_q) + CntW'(1));
      if (fin_q) begin
        out_next.job_finished    = 1'b1;
        out_next.turnaround_time = time_q;
        out_next.waiting_time    = wait_time;
      end
    end else begin
      out_next.all_done = 1'b1;
    end
  end

  // Output register: load on completion, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Scan reads stay inside the loaded part of the table
  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_issue |-> (CntW'(addr_q) < job_cnt_q))
    else $error("scan read beyond job count");

  // A found entry always has work left
  a_grant_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GRANT) |-> (found_q && (rem_q != '0)))
    else $error("grant on an empty entry");

  // The job count never passes the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_cnt_q <= CntW'(MAX_JOBS))
    else $error("job count overflow");

  // A result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten");

endmodule

`default_nettype wire
